// File: rtl/cpu65_pkg.sv
// Shared types, operation codes and constants of the 6502 execute unit.
`timescale 1ns / 1ps
`default_nettype none

package cpu65_pkg;

   // Status flag bit positions: N V U B D I Z C, bit 7 down to 0.
   localparam int unsigned FLAG_C = 0;
   localparam int unsigned FLAG_Z = 1;
   localparam int unsigned FLAG_I = 2;
   localparam int unsigned FLAG_D = 3;
   localparam int unsigned FLAG_B = 4;
   localparam int unsigned FLAG_U = 5;
   localparam int unsigned FLAG_V = 6;
   localparam int unsigned FLAG_N = 7;

   localparam logic [7:0] STATUS_RESET = 8'h30;
   localparam logic [7:0] SP_RESET     = 8'hfd;
   localparam logic [7:0] PULL_MASK    = 8'hcf;
   localparam logic [7:0] BREAK_MASK   = 8'h10;
   localparam logic [7:0] BYTE_ONES    = 8'hff;

   typedef enum logic [5:0] {
      KIND_ADC = 6'd0,  KIND_SBC = 6'd1,  KIND_AND = 6'd2,  KIND_ORA = 6'd3,
      KIND_EOR = 6'd4,  KIND_CMP = 6'd5,  KIND_CPX = 6'd6,  KIND_CPY = 6'd7,
      KIND_BIT = 6'd8,  KIND_ASL = 6'd9,  KIND_LSR = 6'd10, KIND_ROL = 6'd11,
      KIND_ROR = 6'd12, KIND_INC = 6'd13, KIND_DEC = 6'd14, KIND_INX = 6'd15,
      KIND_INY = 6'd16, KIND_DEX = 6'd17, KIND_DEY = 6'd18, KIND_LDA = 6'd19,
      KIND_LDX = 6'd20, KIND_LDY = 6'd21, KIND_STA = 6'd22, KIND_STX = 6'd23,
      KIND_STY = 6'd24, KIND_TAX = 6'd25, KIND_TAY = 6'd26, KIND_TXA = 6'd27,
      KIND_TYA = 6'd28, KIND_TSX = 6'd29, KIND_TXS = 6'd30, KIND_CLC = 6'd31,
      KIND_SEC = 6'd32, KIND_CLI = 6'd33, KIND_SEI = 6'd34, KIND_CLD = 6'd35,
      KIND_SED = 6'd36, KIND_CLV = 6'd37, KIND_BPL = 6'd38, KIND_BMI = 6'd39,
      KIND_BVC = 6'd40, KIND_BVS = 6'd41, KIND_BCC = 6'd42, KIND_BCS = 6'd43,
      KIND_BNE = 6'd44, KIND_BEQ = 6'd45, KIND_SLO = 6'd46, KIND_RLA = 6'd47,
      KIND_SRE = 6'd48, KIND_RRA = 6'd49, KIND_DCP = 6'd50, KIND_ISB = 6'd51,
      KIND_LAX = 6'd52, KIND_SAX = 6'd53, KIND_NOP = 6'd54, KIND_PHA = 6'd55,
      KIND_PHP = 6'd56, KIND_PLP = 6'd57, KIND_PLA = 6'd58
   } kind_type;

   typedef enum logic [1:0] {
      SH_ASL = 2'd0,
      SH_LSR = 2'd1,
      SH_ROL = 2'd2,
      SH_ROR = 2'd3
   } shift_op_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] idx_x;
      logic [7:0] idx_y;
      logic [7:0] sp;
      logic [7:0] status;
   } arch_state_type;

   typedef struct packed {
      logic [5:0] kind;
      logic [7:0] operand;
      logic       on_accumulator;
   } req_item_type;

   typedef struct packed {
      logic [7:0] write_data;
      logic       write_enable;
      logic       branch_taken;
      logic [7:0] acc_out;
      logic [7:0] index_x_out;
      logic [7:0] index_y_out;
      logic [7:0] status_out;
      logic [7:0] stack_ptr_out;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: rtl/cpu65_req_if.sv
// Request channel: one decoded operation and its operand byte.
`timescale 1ns / 1ps
`default_nettype none

interface cpu65_req_if;
   logic       valid;
   logic       ready;
   logic [5:0] kind;
   logic [7:0] operand;
   logic       on_accumulator;

   modport source (output valid, output kind, output operand, output on_accumulator,
                   input ready);
   modport sink   (input valid, input kind, input operand, input on_accumulator,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/cpu65_rsp_if.sv
// Response channel: write-back byte, branch decision and register snapshot.
`timescale 1ns / 1ps
`default_nettype none

interface cpu65_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] write_data;
   logic       write_enable;
   logic       branch_taken;
   logic [7:0] acc_out;
   logic [7:0] index_x_out;
   logic [7:0] index_y_out;
   logic [7:0] status_out;
   logic [7:0] stack_ptr_out;

   modport source (output valid, output write_data, output write_enable,
                   output branch_taken, output acc_out, output index_x_out,
                   output index_y_out, output status_out, output stack_ptr_out,
                   input ready);
   modport sink   (input valid, input write_data, input write_enable,
                   input branch_taken, input acc_out, input index_x_out,
                   input index_y_out, input status_out, input stack_ptr_out,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/cpu65_alu.sv
// Combinational datapath: one operation against the current register state.
`timescale 1ns / 1ps
`default_nettype none

module cpu65_alu
   import cpu65_pkg::*;
(
   input  wire req_item_type   item,
   input  wire arch_state_type cur,
   output arch_state_type      nxt,
   output rsp_item_type        result
);

   kind_type     kind;
   shift_op_type sh_sel;
   logic [7:0]   sh_in;
   logic [7:0]   sh_res;
   logic         sh_carry;
   logic         c_in;
   logic [7:0]   inc_val;
   logic [7:0]   dec_val;
   logic [7:0]   add_b;
   logic         add_c;
   logic [8:0]   sum;
   logic         add_v;
   logic [7:0]   cmp_reg;
   logic [7:0]   cmp_val;
   logic [8:0]   diff;
   logic [7:0]   wd;
   logic         we;
   logic         taken;

   function automatic logic [7:0] with_zn(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] r;
      r         = p;
      r[FLAG_Z] = (v == 8'd0);
      r[FLAG_N] = v[7];
      return r;
   endfunction

   assign kind    = kind_type'(item.kind);
   assign c_in    = cur.status[FLAG_C];
   assign inc_val = item.operand + 8'd1;
   assign dec_val = item.operand - 8'd1;

   // Shifter: selects the shift kind, and A or the operand byte.
   always_comb begin
      case (kind)
         KIND_LSR, KIND_SRE: sh_sel = SH_LSR;
         KIND_ROL, KIND_RLA: sh_sel = SH_ROL;
         KIND_ROR, KIND_RRA: sh_sel = SH_ROR;
         default:            sh_sel = SH_ASL;
      endcase
      case (kind)
         KIND_ASL, KIND_LSR, KIND_ROL, KIND_ROR:
            sh_in = item.on_accumulator ? cur.acc : item.operand;
         default:
            sh_in = item.operand;
      endcase
      case (sh_sel)
         SH_ASL:  begin sh_res = {sh_in[6:0], 1'b0}; sh_carry = sh_in[7]; end
         SH_LSR:  begin sh_res = {1'b0, sh_in[7:1]}; sh_carry = sh_in[0]; end
         SH_ROL:  begin sh_res = {sh_in[6:0], c_in}; sh_carry = sh_in[7]; end
         default: begin sh_res = {c_in, sh_in[7:1]}; sh_carry = sh_in[0]; end
      endcase
   end

   // Adder: RRA takes the rotated byte and its carry, ISB the inverted increment.
   always_comb begin
      case (kind)
         KIND_SBC: begin add_b = ~item.operand; add_c = c_in;     end
         KIND_RRA: begin add_b = sh_res;        add_c = sh_carry; end
         KIND_ISB: begin add_b = ~inc_val;      add_c = c_in;     end
         default:  begin add_b = item.operand;  add_c = c_in;     end
      endcase
      sum   = {1'b0, cur.acc} + {1'b0, add_b} + {8'd0, add_c};
      add_v = (~(cur.acc[7] ^ add_b[7])) & (cur.acc[7] ^ sum[7]);
   end

   // Comparator: borrow out of the 9-bit difference clears carry.
   always_comb begin
      case (kind)
         KIND_CPX: cmp_reg = cur.idx_x;
         KIND_CPY: cmp_reg = cur.idx_y;
         default:  cmp_reg = cur.acc;
      endcase
      cmp_val = (kind == KIND_DCP) ? dec_val : item.operand;
      diff    = {1'b0, cmp_reg} - {1'b0, cmp_val};
   end

   always_comb begin
      nxt   = cur;
      wd    = 8'd0;
      we    = 1'b0;
      taken = 1'b0;
      case (kind)
         KIND_ADC, KIND_SBC, KIND_RRA, KIND_ISB: begin
            nxt.acc                = sum[7:0];
            nxt.status             = with_zn(cur.status, sum[7:0]);
            nxt.status[FLAG_C]     = sum[8];
            nxt.status[FLAG_V]     = add_v;
            if (kind == KIND_RRA) begin
               wd = sh_res;
               we = 1'b1;
            end else if (kind == KIND_ISB) begin
               wd = inc_val;
               we = 1'b1;
            end
         end
         KIND_AND: begin
            nxt.acc    = cur.acc & item.operand;
            nxt.status = with_zn(cur.status, cur.acc & item.operand);
         end
         KIND_ORA: begin
            nxt.acc    = cur.acc | item.operand;
            nxt.status = with_zn(cur.status, cur.acc | item.operand);
         end
         KIND_EOR: begin
            nxt.acc    = cur.acc ^ item.operand;
            nxt.status = with_zn(cur.status, cur.acc ^ item.operand);
         end
         KIND_CMP, KIND_CPX, KIND_CPY, KIND_DCP: begin
            nxt.status         = with_zn(cur.status, diff[7:0]);
            nxt.status[FLAG_C] = ~diff[8];
            if (kind == KIND_DCP) begin
               wd = dec_val;
               we = 1'b1;
            end
         end
         KIND_BIT: begin
            nxt.status[FLAG_N] = item.operand[7];
            nxt.status[FLAG_V] = item.operand[6];
            nxt.status[FLAG_Z] = ((item.operand & cur.acc) == 8'd0);
         end
         KIND_ASL, KIND_LSR, KIND_ROL, KIND_ROR: begin
            nxt.status         = with_zn(cur.status, sh_res);
            nxt.status[FLAG_C] = sh_carry;
            if (item.on_accumulator) begin
               nxt.acc = sh_res;
            end else begin
               wd = sh_res;
               we = 1'b1;
            end
         end
         KIND_SLO, KIND_RLA, KIND_SRE: begin
            wd = sh_res;
            we = 1'b1;
            case (kind)
               KIND_SLO: nxt.acc = cur.acc | sh_res;
               KIND_RLA: nxt.acc = cur.acc & sh_res;
               default:  nxt.acc = cur.acc ^ sh_res;
            endcase
            nxt.status         = with_zn(cur.status, nxt.acc);
            nxt.status[FLAG_C] = sh_carry;
         end
         KIND_INC: begin
            wd         = inc_val;
            we         = 1'b1;
            nxt.status = with_zn(cur.status, inc_val);
         end
         KIND_DEC: begin
            wd         = dec_val;
            we         = 1'b1;
            nxt.status = with_zn(cur.status, dec_val);
         end
         KIND_INX: begin
            nxt.idx_x  = cur.idx_x + 8'd1;
            nxt.status = with_zn(cur.status, nxt.idx_x);
         end
         KIND_INY: begin
            nxt.idx_y  = cur.idx_y + 8'd1;
            nxt.status = with_zn(cur.status, nxt.idx_y);
         end
         KIND_DEX: begin
            nxt.idx_x  = cur.idx_x - 8'd1;
            nxt.status = with_zn(cur.status, nxt.idx_x);
         end
         KIND_DEY: begin
            nxt.idx_y  = cur.idx_y - 8'd1;
            nxt.status = with_zn(cur.status, nxt.idx_y);
         end
         KIND_LDA, KIND_PLA: begin
            nxt.acc    = item.operand;
            nxt.status = with_zn(cur.status, item.operand);
            if (kind == KIND_PLA) begin
               nxt.sp = cur.sp + 8'd1;
            end
         end
         KIND_LAX: begin
            nxt.acc    = item.operand;
            nxt.idx_x  = item.operand;
            nxt.status = with_zn(cur.status, item.operand);
         end
         KIND_LDX: begin
            nxt.idx_x  = item.operand;
            nxt.status = with_zn(cur.status, item.operand);
         end
         KIND_LDY: begin
            nxt.idx_y  = item.operand;
            nxt.status = with_zn(cur.status, item.operand);
         end
         KIND_STA: begin wd = cur.acc;             we = 1'b1; end
         KIND_STX: begin wd = cur.idx_x;           we = 1'b1; end
         KIND_STY: begin wd = cur.idx_y;           we = 1'b1; end
         KIND_SAX: begin wd = cur.acc & cur.idx_x; we = 1'b1; end
         KIND_TAX: begin
            nxt.idx_x  = cur.acc;
            nxt.status = with_zn(cur.status, cur.acc);
         end
         KIND_TAY: begin
            nxt.idx_y  = cur.acc;
            nxt.status = with_zn(cur.status, cur.acc);
         end
         KIND_TXA: begin
            nxt.acc    = cur.idx_x;
            nxt.status = with_zn(cur.status, cur.idx_x);
         end
         KIND_TYA: begin
            nxt.acc    = cur.idx_y;
            nxt.status = with_zn(cur.status, cur.idx_y);
         end
         KIND_TSX: begin
            nxt.idx_x  = cur.sp;
            nxt.status = with_zn(cur.status, cur.sp);
         end
         KIND_TXS: nxt.sp = cur.idx_x;
         KIND_CLC: nxt.status[FLAG_C] = 1'b0;
         KIND_SEC: nxt.status[FLAG_C] = 1'b1;
         KIND_CLI: nxt.status[FLAG_I] = 1'b0;
         KIND_SEI: nxt.status[FLAG_I] = 1'b1;
         KIND_CLD: nxt.status[FLAG_D] = 1'b0;
         KIND_SED: nxt.status[FLAG_D] = 1'b1;
         KIND_CLV: nxt.status[FLAG_V] = 1'b0;
         KIND_BPL: taken = ~cur.status[FLAG_N];
         KIND_BMI: taken =  cur.status[FLAG_N];
         KIND_BVC: taken = ~cur.status[FLAG_V];
         KIND_BVS: taken =  cur.status[FLAG_V];
         KIND_BCC: taken = ~cur.status[FLAG_C];
         KIND_BCS: taken =  cur.status[FLAG_C];
         KIND_BNE: taken = ~cur.status[FLAG_Z];
         KIND_BEQ: taken =  cur.status[FLAG_Z];
         KIND_PHA: begin
            wd     = cur.acc;
            we     = 1'b1;
            nxt.sp = cur.sp - 8'd1;
         end
         KIND_PHP: begin
            // Pushed copy always carries B set.
            wd     = cur.status | BREAK_MASK;
            we     = 1'b1;
            nxt.sp = cur.sp - 8'd1;
         end
         KIND_PLP: begin
            // B drops and U stays set on a pull.
            nxt.sp               = cur.sp + 8'd1;
            nxt.status           = item.operand & PULL_MASK;
            nxt.status[FLAG_U]   = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      result.write_data    = wd;
      result.write_enable  = we;
      result.branch_taken  = taken;
      result.acc_out       = nxt.acc;
      result.index_x_out   = nxt.idx_x;
      result.index_y_out   = nxt.idx_y;
      result.status_out    = nxt.status;
      result.stack_ptr_out = nxt.sp;
   end

endmodule

`default_nettype wire

// File: rtl/cpu_6502_execute_unit.sv
// Top level of the 6502 execute unit: request register, datapath, register file, result register.
`timescale 1ns / 1ps
`default_nettype none

// Execute stage of a 6502 core without decimal mode. Each request transaction
// carries one decoded operation kind, its operand byte (immediate, memory read
// or pulled stack byte) and, for ASL/LSR/ROL/ROR, whether it acts on A. The
// unit holds A, X, Y, SP and the status byte (N V U B D I Z C) and answers each
// request with exactly one response transaction: the byte to write back or
// push, its write enable (zero data when no write), the branch decision for
// branch kinds, and all registers after the operation. Throughput is one
// transaction per cycle while the response side is ready; each operation goes
// from the request register through the datapath into the response register.
// The datapath is one 8-bit add, compare or shift plus selection, so back-to-back
// operations see the registers left by the previous one with no hazard. Kinds
// 59 to 63 act as no operation. After reset A, X, Y are 0, SP 0xfd, status 0x30.
module cpu_6502_execute_unit
   import cpu65_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   cpu65_req_if.sink   req,
   cpu65_rsp_if.source rsp
);

   logic           req_valid_ff;
   logic           req_valid_in;
   req_item_type   req_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   rsp_item_type   rsp_ff;
   arch_state_type arch_ff;
   arch_state_type arch_in;
   rsp_item_type   alu_result;
   logic           advance;
   logic           req_take;

   // Advance the held request into the response register when that register
   // is empty or drains this cycle.
   assign advance   = req_valid_ff & (~rsp_valid_ff | rsp.ready);
   assign req.ready = ~req_valid_ff | advance;
   assign req_take  = req.valid & req.ready;

   assign req_valid_in = req_take | (req_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp.ready);

   cpu65_alu u_alu (
      .item   (req_ff),
      .cur    (arch_ff),
      .nxt    (arch_in),
      .result (alu_result)
   );

   // Control state and architectural registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         arch_ff.acc    <= 8'd0;
         arch_ff.idx_x  <= 8'd0;
         arch_ff.idx_y  <= 8'd0;
         arch_ff.sp     <= SP_RESET;
         arch_ff.status <= STATUS_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // Commit register updates only when the transaction moves on.
         if (advance) begin
            arch_ff <= arch_in;
         end
      end
   end

   // Payload registers: capture on acceptance, hold while stalled.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.kind           <= req.kind;
         req_ff.operand        <= req.operand;
         req_ff.on_accumulator <= req.on_accumulator;
      end
      if (advance) begin
         rsp_ff <= alu_result;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.write_data    = rsp_ff.write_data;
   assign rsp.write_enable  = rsp_ff.write_enable;
   assign rsp.branch_taken  = rsp_ff.branch_taken;
   assign rsp.acc_out       = rsp_ff.acc_out;
   assign rsp.index_x_out   = rsp_ff.index_x_out;
   assign rsp.index_y_out   = rsp_ff.index_y_out;
   assign rsp.status_out    = rsp_ff.status_out;
   assign rsp.stack_ptr_out = rsp_ff.stack_ptr_out;

endmodule

`default_nettype wire
